### rtl/core/fsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared types and constants of the framed serial receiver.
// ----------------------------------------------------------------------------
package fsr_pkg;

  // Default depth of the body store
  localparam int MAX_BODY_DEF = 32;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int ROUTE_W   = 16;
  localparam int OIDX_W    = 5;
  localparam int POS_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 48;

  // Bytes between the sync byte and the first body byte
  localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(4);

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] SYNC_RST   = 8'h00;
  localparam logic [LEN_W-1:0]  MAXLEN_RST = 6'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd1;

  // Role of the next byte within a frame
  typedef enum logic [2:0] {
    POS_CMD,
    POS_LEN,
    POS_RHI,
    POS_RLO,
    POS_BODY,
    POS_CSUM
  } pos_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic pos_clr;     // restart the frame position
    logic hdr_take;    // capture the current byte by its role
    logic load_empty;  // load the empty-frame result
    logic rd_clr;      // restart the read index
    logic load_body;   // load a body result from the store
    logic rd_inc;      // advance the read index
  } fsr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic      is_sync;
    pos_kind_t pos_kind;
    logic      len_bad;
    logic      sum_ok;
    logic      len_zero;
    logic      rd_last;
  } fsr_status_t;

endpackage

### rtl/core/fsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_ctrl
// Frame sequencer: tracks idle/in-frame and runs the output run of a frame.
// ----------------------------------------------------------------------------
module fsr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fsr_pkg::fsr_status_t st,
  output fsr_pkg::fsr_cmd_t    cmd
);
  import fsr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FRAME,
    S_READ,
    S_SHOW
  } state_t;

  state_t state_r, state_nxt;
  logic   in_xfer;
  logic   out_xfer;

  assign in_ready  = (state_r == S_IDLE) || (state_r == S_FRAME);
  assign out_valid = (state_r == S_SHOW);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  // Decode next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && st.is_sync) begin
          cmd.pos_clr = 1'b1;
          state_nxt   = S_FRAME;
        end
      end
      S_FRAME: begin
        if (in_xfer) begin
          if (st.pos_kind == POS_CSUM) begin
            if (!st.sum_ok) begin
              state_nxt = S_IDLE;
            end else if (st.len_zero) begin
              cmd.load_empty = 1'b1;
              state_nxt      = S_SHOW;
            end else begin
              cmd.rd_clr = 1'b1;
              state_nxt  = S_READ;
            end
          end else if (st.pos_kind == POS_LEN && st.len_bad) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.hdr_take = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.load_body = 1'b1;
        state_nxt     = S_SHOW;
      end
      S_SHOW: begin
        if (out_xfer) begin
          if (st.rd_last || st.len_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_inc = 1'b1;
            state_nxt  = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/fsr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_datapath
// Configuration, header capture, checksum, body store and output register.
// ----------------------------------------------------------------------------
module fsr_datapath #(
  parameter int MAX_BODY = fsr_pkg::MAX_BODY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fsr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fsr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic [fsr_pkg::BYTE_W-1:0]    rx_byte,
  input  fsr_pkg::fsr_cmd_t             cmd,
  output fsr_pkg::fsr_status_t          st,
  output logic [fsr_pkg::OUT_W-1:0]     out_data,
  output logic                          out_has,
  output logic                          out_last
);
  import fsr_pkg::*;

  localparam int IDX_W = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;

  logic [BYTE_W-1:0]  sync_r;
  logic [LEN_W-1:0]   maxlen_r;
  logic [POS_W-1:0]   pos_r;
  logic [BYTE_W-1:0]  cmd_r;
  logic [LEN_W-1:0]   len_r;
  logic [ROUTE_W-1:0] route_r;
  logic [BYTE_W-1:0]  sum_r;
  logic [LEN_W-1:0]   rd_idx_r;
  logic [OIDX_W-1:0]  oidx_r;
  logic [BYTE_W-1:0]  obyte_r;
  logic               ohas_r;
  logic               olast_r;
  logic [BYTE_W-1:0]  body_mem [MAX_BODY];

  logic [POS_W-1:0]   body_end;
  logic [POS_W-1:0]   body_addr;
  logic [BYTE_W-1:0]  sum_add;
  pos_kind_t          kind;

  // Classify the current byte by frame position
  assign body_end  = POS_W'(len_r) + HEADER_BYTES;
  assign body_addr = pos_r - HEADER_BYTES;
  assign sum_add   = sum_r + rx_byte;

  always_comb begin
    case (pos_r)
      POS_W'(0): kind = POS_CMD;
      POS_W'(1): kind = POS_LEN;
      POS_W'(2): kind = POS_RHI;
      POS_W'(3): kind = POS_RLO;
      default:   kind = (pos_r < body_end) ? POS_BODY : POS_CSUM;
    endcase
  end

  assign st.is_sync  = (rx_byte == sync_r);
  assign st.pos_kind = kind;
  assign st.len_bad  = (rx_byte > BYTE_W'(maxlen_r)) || (rx_byte > BYTE_W'(MAX_BODY));
  assign st.sum_ok   = (sum_r == rx_byte);
  assign st.len_zero = (len_r == '0);
  assign st.rd_last  = ((rd_idx_r + LEN_W'(1)) == len_r);

  // Write configuration registers; other indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r   <= SYNC_RST;
      maxlen_r <= MAXLEN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SYNC_BYTE:  sync_r   <= cfg_wdata;
        REG_MAX_LENGTH: maxlen_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Track position, header fields and checksum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      cmd_r    <= '0;
      len_r    <= '0;
      route_r  <= '0;
      sum_r    <= '0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.pos_clr) begin
        pos_r <= '0;
      end else if (cmd.hdr_take) begin
        pos_r <= pos_r + POS_W'(1);
        case (kind)
          POS_CMD: begin
            cmd_r <= rx_byte;
            sum_r <= rx_byte;
          end
          POS_LEN: begin
            len_r <= rx_byte[LEN_W-1:0];
            sum_r <= sum_add;
          end
          POS_RHI: begin
            route_r[ROUTE_W-1:BYTE_W] <= rx_byte;
            sum_r                     <= sum_add;
          end
          default: begin
            if (kind == POS_RLO) begin
              route_r[BYTE_W-1:0] <= rx_byte;
            end
            sum_r <= sum_add;
          end
        endcase
      end
      if (cmd.rd_clr) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_inc) begin
        rd_idx_r <= rd_idx_r + LEN_W'(1);
      end
    end
  end

  // Store body bytes; read one into the output register
  always_ff @(posedge clk) begin
    if (cmd.hdr_take && kind == POS_BODY) begin
      body_mem[body_addr[IDX_W-1:0]] <= rx_byte;
    end
    if (cmd.load_body) begin
      obyte_r <= body_mem[rd_idx_r[IDX_W-1:0]];
      oidx_r  <= rd_idx_r[OIDX_W-1:0];
      ohas_r  <= 1'b1;
      olast_r <= st.rd_last;
    end else if (cmd.load_empty) begin
      obyte_r <= '0;
      oidx_r  <= '0;
      ohas_r  <= 1'b0;
      olast_r <= 1'b1;
    end
  end

  assign out_data = {5'b0, obyte_r, oidx_r, route_r, len_r, cmd_r};
  assign out_has  = ohas_r;
  assign out_last = olast_r;

endmodule

### rtl/core/framed_serial_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_serial_receiver
// Sync-framed byte receiver with additive checksum and per-byte output run.
// ----------------------------------------------------------------------------
// Received bytes are accepted while in_tready is high, which holds while the block
// waits for a sync byte or collects a frame. A frame is sync, command,
// length, route high, route low, body bytes and a checksum (sum modulo 256
// of all bytes after sync). When a good checksum arrives, input stalls and
// the frame is sent as one transfer per body byte (or one empty transfer for
// a zero-length frame). Each body transfer first reads the body store
// through its single registered read port into the output register, then
// presents it. The empty transfer is presented in the cycle right after its
// checksum byte. A low out_tready holds the presented transfer. Input is
// ready again in the cycle after the last transfer of the run.
// Frames with a bad checksum or a length above max_length or MAX_BODY are
// dropped without output. The configuration port is always ready.
// ----------------------------------------------------------------------------
module framed_serial_receiver #(
  parameter int MAX_BODY = fsr_pkg::MAX_BODY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsr_pkg::BYTE_W-1:0]    cfg_data,
  // received bytes
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  // frame results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] command, [13:8] body_length, [29:14] route, [34:30] body_index,
  // [42:35] body_byte, [47:43] zero
  output logic [fsr_pkg::OUT_W-1:0]     out_tdata,
  output logic [0:0]                    out_tuser,  // [0] has_body
  output logic                          out_tlast   // last
);
  import fsr_pkg::*;

  fsr_cmd_t    cmd;
  fsr_status_t st;

  assign cfg_ready = 1'b1;

  fsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .st        (st),
    .cmd       (cmd)
  );

  fsr_datapath #(
    .MAX_BODY (MAX_BODY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .rx_byte   (in_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_tdata),
    .out_has   (out_tuser[0]),
    .out_last  (out_tlast)
  );

endmodule

### tb/sv/tb_framed_serial_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_serial_receiver
// Self-checking bench for the sync-framed serial byte receiver.
// ----------------------------------------------------------------------------
// Byte streams go into the receiver one transfer at a time. A bit-accurate
// frame decoder in the bench follows every accepted byte and queues the
// results that a good frame produces. Each output transfer is checked field
// by field against the oldest queued result. Directed frames cover empty
// and full frames, the sync value as data, bad checksums and length aborts;
// random phases then mix well-formed frames with noise and broken frames
// under several sync, length-limit and back-pressure settings.
// ----------------------------------------------------------------------------
module tb_framed_serial_receiver;
  import fsr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS    = 40;
  localparam int PHASE_ITEMS   = 52;

  // One result transfer of an accepted frame
  typedef struct packed {
    logic [7:0]  command;
    logic [5:0]  body_length;
    logic [15:0] route;
    logic        has_body;
    logic [4:0]  body_index;
    logic [7:0]  body_byte;
    logic        last;
  } frame_item_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic [0:0]           out_tuser;
  logic                 out_tlast;

  // Bench copy of the configuration
  logic [7:0] sync_cfg   = SYNC_RST;
  logic [5:0] maxlen_cfg = MAXLEN_RST;

  // Bench copy of the frame decoder state
  logic       rx_in_frame = 1'b0;
  int         rx_pos      = 0;
  logic [7:0] rx_cmd      = '0;
  logic [5:0] rx_len      = '0;
  logic [15:0] rx_route   = '0;
  logic [7:0] rx_sum      = '0;
  logic [7:0] rx_body [MAX_BODY_DEF];

  frame_item_t pending_items[$];
  logic [7:0]  frame_body [MAX_BODY_DEF];

  int gap_pct       = 0;
  int stall_pct     = 0;
  int err_count     = 0;
  int counted_items = 0;
  int cycle_count   = 0;

  framed_serial_receiver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("framed_serial_receiver test failed");
    $finish;
  end

  // Follow one accepted byte and queue the results it releases
  function automatic void decode_rx_byte(input logic [7:0] b);
    frame_item_t item;
    int i;
    if (!rx_in_frame) begin
      if (b == sync_cfg) begin
        rx_in_frame = 1'b1;
        rx_pos      = 0;
      end
      return;
    end
    if (rx_pos == 0) begin
      rx_cmd = b;
      rx_sum = b;
    end else if (rx_pos == 1) begin
      // drop the frame on an oversized length
      if (b > maxlen_cfg || b > MAX_BODY_DEF) begin
        rx_in_frame = 1'b0;
        return;
      end
      rx_len = b[5:0];
      rx_sum = rx_sum + b;
    end else if (rx_pos == 2) begin
      rx_route = {b, 8'h00};
      rx_sum   = rx_sum + b;
    end else if (rx_pos == 3) begin
      rx_route[7:0] = b;
      rx_sum        = rx_sum + b;
    end else if (rx_pos < rx_len + 4) begin
      rx_body[rx_pos-4] = b;
      rx_sum            = rx_sum + b;
    end else begin
      // checksum byte closes the frame
      rx_in_frame = 1'b0;
      if (rx_sum == b) begin
        item.command     = rx_cmd;
        item.body_length = rx_len;
        item.route       = rx_route;
        if (rx_len == 0) begin
          item.has_body   = 1'b0;
          item.body_index = '0;
          item.body_byte  = '0;
          item.last       = 1'b1;
          pending_items.push_back(item);
        end else begin
          for (i = 0; i < rx_len; i++) begin
            item.has_body   = 1'b1;
            item.body_index = i[4:0];
            item.body_byte  = rx_body[i];
            item.last       = (i == rx_len - 1);
            pending_items.push_back(item);
          end
        end
      end
      return;
    end
    rx_pos++;
  endfunction

  task automatic log_mismatch(input string what, input int unsigned got,
                              input int unsigned want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
               $realtime, what, got, want);
  endtask

  // Compare one output transfer against the oldest queued result
  task automatic compare_frame_item();
    frame_item_t want;
    if (pending_items.size() == 0) begin
      log_mismatch("unexpected result (command)", out_tdata[7:0], 0);
      return;
    end
    want = pending_items.pop_front();
    if (out_tdata[7:0] !== want.command)
      log_mismatch("command", out_tdata[7:0], want.command);
    if (out_tdata[13:8] !== want.body_length)
      log_mismatch("body_length", out_tdata[13:8], want.body_length);
    if (out_tdata[29:14] !== want.route)
      log_mismatch("route", out_tdata[29:14], want.route);
    if (out_tuser[0] !== want.has_body)
      log_mismatch("has_body", out_tuser[0], want.has_body);
    if (out_tdata[34:30] !== want.body_index)
      log_mismatch("body_index", out_tdata[34:30], want.body_index);
    if (out_tdata[42:35] !== want.body_byte)
      log_mismatch("body_byte", out_tdata[42:35], want.body_byte);
    if (out_tlast !== want.last)
      log_mismatch("last", out_tlast, want.last);
  endtask

  // Check each result transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) compare_frame_item();
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (rx_in_frame || b == sync_cfg) counted_items++;
    decode_rx_byte(b);
  endtask

  // Send sync, header, body from frame_body and a checksum offset by skew
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len_byte,
                            input logic [15:0] route, input logic [7:0] skew);
    logic [7:0] sum;
    int i;
    sum = cmd + len_byte + route[15:8] + route[7:0];
    send_byte(sync_cfg);
    send_byte(cmd);
    send_byte(len_byte);
    if (!rx_in_frame) return;
    send_byte(route[15:8]);
    send_byte(route[7:0]);
    for (i = 0; i < len_byte; i++) begin
      sum = sum + frame_body[i];
      send_byte(frame_body[i]);
    end
    sum = sum + skew;
    send_byte(sum);
  endtask

  // Drop valid and wait until every queued result has arrived
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SYNC_BYTE) sync_cfg = val;
    else if (idx == REG_MAX_LENGTH) maxlen_cfg = val[5:0];
  endtask

  // Close any open frame and drain results before a register write
  task automatic apply_config(input logic [7:0] sync_val, input logic [5:0] maxlen_val);
    while (rx_in_frame) send_byte(8'($urandom_range(255)));
    settle();
    write_reg(REG_SYNC_BYTE, sync_val);
    write_reg(REG_MAX_LENGTH, {2'b00, maxlen_val});
    cfg_valid <= 1'b0;
  endtask

  // Fill the body with random bytes, now and then the sync value
  task automatic fill_body(input int len);
    int i;
    for (i = 0; i < len; i++)
      frame_body[i] = ($urandom_range(7) == 0) ? sync_cfg : 8'($urandom_range(255));
  endtask

  // One random sequence: mostly good frames, some broken frames and noise
  task automatic send_random_frame();
    int kind;
    int len;
    int small_max;
    logic [7:0] b;
    logic [7:0] cmd;
    logic [15:0] route;
    // finish any frame left open by a truncated sequence
    while (rx_in_frame) send_byte(8'($urandom_range(255)));
    kind      = $urandom_range(99);
    cmd       = 8'($urandom_range(255));
    route     = 16'($urandom_range(65535));
    small_max = (maxlen_cfg < 6) ? maxlen_cfg : 6;
    len       = ($urandom_range(99) < 15) ? maxlen_cfg : $urandom_range(small_max, 0);
    fill_body(len);
    if (kind < 70) begin
      send_frame(cmd, 8'(len), route, 8'd0);
    end else if (kind < 80) begin
      send_frame(cmd, 8'(len), route, 8'($urandom_range(255, 1)));
    end else if (kind < 88) begin
      send_frame(cmd, 8'($urandom_range(255, maxlen_cfg + 1)), route, 8'd0);
    end else if (kind < 94) begin
      // idle noise that never hits the sync value
      repeat ($urandom_range(4, 1)) begin
        b = 8'($urandom_range(255));
        if (b == sync_cfg) b = ~b;
        send_byte(b);
      end
    end else begin
      // cut a frame short inside its header
      send_byte(sync_cfg);
      send_byte(cmd);
      if (kind < 97) send_byte(8'(len));
    end
  endtask

  // Empty and short frames, sync as data, bad checksum, length aborts
  task automatic test_frame_basics();
    gap_pct   = 0;
    stall_pct = 0;
    send_byte(8'h55);
    send_frame(8'hFF, 8'd0, 16'hFF00, 8'd0);
    frame_body[0] = sync_cfg;
    frame_body[1] = 8'hFF;
    send_frame(8'h00, 8'd2, 16'h00FF, 8'd0);
    send_frame(8'h12, 8'd0, 16'h3456, 8'd1);
    send_frame(8'h01, 8'd33, 16'h0000, 8'd0);
    send_frame(8'h01, 8'd255, 16'h0000, 8'd0);
  endtask

  // Length limit at one and at zero, with a new sync value
  task automatic test_length_limits();
    gap_pct   = 14;
    stall_pct = 14;
    apply_config(8'hA5, 6'd1);
    send_byte(8'h00);
    frame_body[0] = 8'hA5;
    frame_body[1] = 8'h5A;
    send_frame(8'h80, 8'd2, 16'h1234, 8'd0);
    send_frame(8'h80, 8'd1, 16'h1234, 8'd0);
    apply_config(8'hA5, 6'd0);
    send_frame(8'h7F, 8'd0, 16'hFFFF, 8'd0);
    send_frame(8'h7F, 8'd1, 16'hFFFF, 8'd0);
  endtask

  // Random traffic under one setting, led by a full-length frame
  task automatic test_random_traffic(input int gap, input int stall,
                                     input logic [7:0] sync_val,
                                     input logic [5:0] maxlen_val);
    int goal;
    apply_config(sync_val, maxlen_val);
    gap_pct   = gap;
    stall_pct = stall;
    goal      = counted_items + PHASE_ITEMS;
    fill_body(maxlen_cfg);
    send_frame(8'($urandom_range(255)), 8'(maxlen_cfg), 16'($urandom_range(65535)), 8'd0);
    while (counted_items < goal) send_random_frame();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_frame_basics();
    test_length_limits();
    test_random_traffic(0, 0, 8'hFF, 6'd32);
    test_random_traffic(74, 0, 8'($urandom_range(255)), 6'($urandom_range(32)));
    test_random_traffic(0, 74, 8'h00, 6'd32);
    test_random_traffic(14, 14, 8'($urandom_range(255)), 6'd16);
    settle();
    if (err_count == 0) begin
      $display("framed_serial_receiver test passed");
    end else begin
      $display("framed_serial_receiver test failed");
    end
    $finish;
  end

endmodule
